// ===== sv/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg - shared definitions for the LRU cache tracker
// Field widths, configuration register indexes, reset values and the
// sequencer state type used across the tracker's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

	localparam int DEF_MAX_SET_BITS = 8;
	localparam int DEF_WAYS         = 8;
	localparam int DEF_COUNT_WIDTH  = 48;

	localparam int ADDR_W  = 64;
	localparam int TAG_W   = 64;
	localparam int TOTAL_W = 48;
	localparam int DIRTY_W = 12;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

	localparam logic [3:0] RST_SET_BITS   = 4'd4;
	localparam logic [3:0] RST_WAYS_USED  = 4'd1;
	localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_STORE = 1'b1;

	typedef struct packed {
		logic valid;
		logic dirty;
	} line_flags_t;

	// Outcome of one set scan, as the commit step needs it.
	typedef struct packed {
		logic hit;
		logic evict;
		logic old_dirty;
	} scan_result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_B,
		S_SHIFT_S,
		S_READ,
		S_CMP,
		S_COMMIT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/slc_req_if.sv =====
// ----------------------------------------------------------------------------
// slc_req_if - request channel
// One load or store access per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_req_if;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [slc_pkg::ADDR_W-1:0] address;

	modport source (output valid, output req_type, output address, input ready);
	modport sink   (input valid, input req_type, input address, output ready);
endinterface

`default_nettype wire

// ===== sv/slc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slc_rsp_if - result channel
// Per-access outcome flags and running totals, one beat per access.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        was_hit;
	logic                        was_eviction;
	logic                        evicted_dirty;
	logic [slc_pkg::TOTAL_W-1:0] hit_total;
	logic [slc_pkg::TOTAL_W-1:0] miss_total;
	logic [slc_pkg::TOTAL_W-1:0] eviction_total;
	logic [slc_pkg::DIRTY_W-1:0] dirty_resident_blocks;
	logic [slc_pkg::TOTAL_W-1:0] dirty_evicted_total;

	modport source (
		output valid, output was_hit, output was_eviction, output evicted_dirty,
		output hit_total, output miss_total, output eviction_total,
		output dirty_resident_blocks, output dirty_evicted_total,
		input ready
	);
	modport sink (
		input valid, input was_hit, input was_eviction, input evicted_dirty,
		input hit_total, input miss_total, input eviction_total,
		input dirty_resident_blocks, input dirty_evicted_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/slc_line_store.sv =====
// ----------------------------------------------------------------------------
// slc_line_store - line state memory
// Holds valid/dirty flags, tags and LRU stamps for every line, one read and
// one write per cycle with registered read data. Clears the flags after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_line_store #(
	parameter int SET_W   = 8,
	parameter int WAY_W   = 3,
	parameter int STAMP_W = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire logic [SET_W+WAY_W-1:0]      rd_addr,
	input  wire logic                        wr_en,
	input  wire logic [SET_W+WAY_W-1:0]      wr_addr,
	input  wire slc_pkg::line_flags_t        wr_flags,
	input  wire logic [slc_pkg::TAG_W-1:0]   wr_tag,
	input  wire logic [STAMP_W-1:0]          wr_stamp,
	output slc_pkg::line_flags_t             rd_flags,
	output logic [slc_pkg::TAG_W-1:0]        rd_tag,
	output logic [STAMP_W-1:0]               rd_stamp,
	output logic                             clear_busy
);

	localparam int LINE_AW = SET_W + WAY_W;
	localparam int DEPTH   = 1 << LINE_AW;

	slc_pkg::line_flags_t              flags_mem [DEPTH];
	logic [slc_pkg::TAG_W-1:0]         tag_mem   [DEPTH];
	logic [STAMP_W-1:0]                stamp_mem [DEPTH];

	slc_pkg::line_flags_t              rd_flags_q;
	logic [slc_pkg::TAG_W-1:0]         rd_tag_q;
	logic [STAMP_W-1:0]                rd_stamp_q;
	logic [LINE_AW:0]                  clr_q;

	assign clear_busy = ~clr_q[LINE_AW];

	// The sweep counter stops once its top bit sets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clear_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy) begin
			flags_mem[clr_q[LINE_AW-1:0]] <= '0;
		end else if (wr_en) begin
			flags_mem[wr_addr] <= wr_flags;
		end
		if (wr_en) begin
			tag_mem[wr_addr]   <= wr_tag;
			stamp_mem[wr_addr] <= wr_stamp;
		end
		if (rd_en) begin
			rd_flags_q <= flags_mem[rd_addr];
			rd_tag_q   <= tag_mem[rd_addr];
			rd_stamp_q <= stamp_mem[rd_addr];
		end
	end

	assign rd_flags = rd_flags_q;
	assign rd_tag   = rd_tag_q;
	assign rd_stamp = rd_stamp_q;

endmodule

`default_nettype wire

// ===== sv/slc_way_scan.sv =====
// ----------------------------------------------------------------------------
// slc_way_scan - shared way compare unit
// Compares one way per step against the lookup tag and tracks the hit way,
// the first free way and the least recently used way of the set.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_way_scan #(
	parameter int WAY_W   = 3,
	parameter int STAMP_W = 48
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      cmp_en,
	input  wire logic [WAY_W-1:0]          way,
	input  wire slc_pkg::line_flags_t      rd_flags,
	input  wire logic [slc_pkg::TAG_W-1:0] rd_tag,
	input  wire logic [STAMP_W-1:0]        rd_stamp,
	input  wire logic [slc_pkg::TAG_W-1:0] tag,
	output logic                           hit_now,
	output slc_pkg::scan_result_t          result,
	output logic [WAY_W-1:0]               target_way
);

	logic               hit_q;
	logic               hit_dirty_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic               free_q;
	logic [WAY_W-1:0]   free_way_q;
	logic [WAY_W-1:0]   victim_way_q;
	logic               victim_dirty_q;
	logic [STAMP_W-1:0] min_stamp_q;
	logic               older;

	assign hit_now = rd_flags.valid && (rd_tag == tag);

	// Strict less-than keeps the lowest way on equal stamps.
	assign older = (way == '0) || (rd_stamp < min_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmp_en) begin
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (!rd_flags.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			if (hit_now) begin
				hit_way_q   <= way;
				hit_dirty_q <= rd_flags.dirty;
			end
			if (!rd_flags.valid && !free_q) begin
				free_way_q <= way;
			end
			if (rd_flags.valid && older) begin
				min_stamp_q    <= rd_stamp;
				victim_way_q   <= way;
				victim_dirty_q <= rd_flags.dirty;
			end
		end
	end

	always_comb begin
		result.hit       = hit_q;
		result.evict     = !hit_q && !free_q;
		result.old_dirty = 1'b0;
		target_way       = free_way_q;
		if (hit_q) begin
			result.old_dirty = hit_dirty_q;
			target_way       = hit_way_q;
		end else if (!free_q) begin
			result.old_dirty = victim_dirty_q;
			target_way       = victim_way_q;
		end
	end

endmodule

`default_nettype wire

// ===== sv/set_assoc_lru_cache_tracker.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker - tag-only set-associative LRU cache tracker
// Tracks hits, misses, evictions and dirty lines of a write-back cache.
//
//   port        dir     beat contents
//   ----------  ------  ---------------------------------------------------
//   req         sink    req_type (load/store), 64-bit byte address
//   rsp         source  hit/eviction/dirty flags, saturating totals
//   cfg_*       in      register writes: set_bits, ways_used, block_bits
//
// An access holds the block through two shifter passes, then one memory read
// and one compare per way, up to and including a hit or to the end of the
// set, then one commit, after which it returns to idle. The result beat is
// registered at the commit, and the next request can be taken once the block
// is back in idle. After reset the line flags are swept clear, one line per
// cycle, across all 2^(set index bits + way index bits) lines (2048 at the
// defaults); no request is taken meanwhile. A result waits in the output
// register while the next access runs; that access stalls before its commit
// until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tracker #(
	parameter int MAX_SET_BITS = slc_pkg::DEF_MAX_SET_BITS,
	parameter int WAYS         = slc_pkg::DEF_WAYS,
	parameter int COUNT_WIDTH  = slc_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	slc_req_if.sink                               req,
	slc_rsp_if.source                             rsp,
	input  wire logic                             cfg_we,
	input  wire logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [slc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int XW    = (COUNT_WIDTH > slc_pkg::TOTAL_W) ? COUNT_WIDTH : slc_pkg::TOTAL_W;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
		input logic en);
		sat_inc = (en && (v != '1)) ? v + 1'b1 : v;
	endfunction

	function automatic logic [slc_pkg::TOTAL_W-1:0] out_sat(input logic [COUNT_WIDTH-1:0] v);
		logic [XW-1:0] w;
		w = XW'(v);
		out_sat = (w > XW'(slc_pkg::TOTAL_MAX)) ? slc_pkg::TOTAL_MAX
			: w[slc_pkg::TOTAL_W-1:0];
	endfunction

	slc_pkg::state_t state_q, state_d;

	// Configuration registers
	logic [3:0] set_bits_q;
	logic [3:0] ways_used_q;
	logic [5:0] block_bits_q;

	// Access context
	logic                          store_q;
	logic [slc_pkg::ADDR_W-1:0]    address_q;
	logic [slc_pkg::ADDR_W-1:0]    shifted_q;
	logic [slc_pkg::TAG_W-1:0]     tag_q;
	logic [SET_W-1:0]              set_q;
	logic [WAY_W-1:0]              way_q;

	// Counters
	logic [COUNT_WIDTH-1:0]        access_q;
	logic [COUNT_WIDTH-1:0]        hits_q;
	logic [COUNT_WIDTH-1:0]        misses_q;
	logic [COUNT_WIDTH-1:0]        evictions_q;
	logic [COUNT_WIDTH-1:0]        dirty_out_q;
	logic [slc_pkg::DIRTY_W-1:0]   dirty_now_q;

	// Output register
	logic out_valid_q;
	logic was_hit_q;
	logic was_eviction_q;
	logic evicted_dirty_q;

	// Control
	logic                          accept;
	logic                          out_free;
	logic                          commit;
	logic                          rd_en;
	logic                          cmp_en;
	logic                          scan_start;
	logic                          shift_first;
	logic                          clear_busy;
	logic [WAY_W-1:0]              last_way;
	logic [4:0]                    s_eff;
	logic [5:0]                    shift_amt;
	logic [slc_pkg::ADDR_W-1:0]    shift_in;
	logic [slc_pkg::ADDR_W-1:0]    shift_out;
	logic [SET_W-1:0]              set_mask;

	// Memory and scan connections
	slc_pkg::line_flags_t          rd_flags;
	slc_pkg::line_flags_t          wr_flags;
	logic [slc_pkg::TAG_W-1:0]     rd_tag;
	logic [COUNT_WIDTH-1:0]        rd_stamp;
	logic                          hit_now;
	slc_pkg::scan_result_t         scan_res;
	logic [WAY_W-1:0]              target_way;
	logic                          dirty_inc;
	logic                          dirty_dec;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= slc_pkg::RST_SET_BITS;
			ways_used_q  <= slc_pkg::RST_WAYS_USED;
			block_bits_q <= slc_pkg::RST_BLOCK_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_wdata[3:0];
				slc_pkg::REG_WAYS_USED:  ways_used_q  <= cfg_wdata[3:0];
				slc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective geometry: set bits capped, ways kept within 1..WAYS.
	always_comb begin
		s_eff = (int'(set_bits_q) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : 5'(set_bits_q);
		if (ways_used_q == '0) begin
			last_way = '0;
		end else if (int'(ways_used_q) > WAYS) begin
			last_way = WAY_W'(WAYS - 1);
		end else begin
			last_way = WAY_W'(ways_used_q - 4'd1);
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slc_pkg::S_IDLE:    if (accept) state_d = slc_pkg::S_SHIFT_B;
			slc_pkg::S_SHIFT_B: state_d = slc_pkg::S_SHIFT_S;
			slc_pkg::S_SHIFT_S: state_d = slc_pkg::S_READ;
			slc_pkg::S_READ:    state_d = slc_pkg::S_CMP;
			slc_pkg::S_CMP: begin
				if (hit_now || (way_q == last_way)) begin
					state_d = slc_pkg::S_COMMIT;
				end else begin
					state_d = slc_pkg::S_READ;
				end
			end
			slc_pkg::S_COMMIT:  if (out_free) state_d = slc_pkg::S_IDLE;
			default:            state_d = slc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready   = 1'b0;
		rd_en       = 1'b0;
		cmp_en      = 1'b0;
		scan_start  = 1'b0;
		shift_first = 1'b0;
		commit      = 1'b0;
		unique case (state_q)
			slc_pkg::S_IDLE:    req.ready   = !clear_busy;
			slc_pkg::S_SHIFT_B: shift_first = 1'b1;
			slc_pkg::S_SHIFT_S: scan_start  = 1'b1;
			slc_pkg::S_READ:    rd_en       = 1'b1;
			slc_pkg::S_CMP:     cmp_en      = 1'b1;
			slc_pkg::S_COMMIT:  commit      = out_free;
			default: ;
		endcase
	end

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// ---------------------------------------------------- shared shifter
	// First pass drops the block offset, second pass drops the set index.
	assign shift_in  = shift_first ? address_q : shifted_q;
	assign shift_amt = shift_first ? block_bits_q : 6'(s_eff);
	assign shift_out = shift_in >> shift_amt;
	assign set_mask  = ~({SET_W{1'b1}} << s_eff);

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q   <= req.req_type;
			address_q <= req.address;
		end
		if (shift_first) begin
			shifted_q <= shift_out;
		end
		if (scan_start) begin
			tag_q <= shift_out;
			set_q <= shifted_q[SET_W-1:0] & set_mask;
		end
		if (scan_start) begin
			way_q <= '0;
		end else if (cmp_en && !hit_now && (way_q != last_way)) begin
			way_q <= way_q + 1'b1;
		end
	end

	// ------------------------------------------------------ line memory
	slc_line_store #(
		.SET_W   (SET_W),
		.WAY_W   (WAY_W),
		.STAMP_W (COUNT_WIDTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    ({set_q, way_q}),
		.wr_en      (commit),
		.wr_addr    ({set_q, target_way}),
		.wr_flags   (wr_flags),
		.wr_tag     (tag_q),
		.wr_stamp   (access_q),
		.rd_flags   (rd_flags),
		.rd_tag     (rd_tag),
		.rd_stamp   (rd_stamp),
		.clear_busy (clear_busy)
	);

	slc_way_scan #(
		.WAY_W   (WAY_W),
		.STAMP_W (COUNT_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.cmp_en     (cmp_en),
		.way        (way_q),
		.rd_flags   (rd_flags),
		.rd_tag     (rd_tag),
		.rd_stamp   (rd_stamp),
		.tag        (tag_q),
		.hit_now    (hit_now),
		.result     (scan_res),
		.target_way (target_way)
	);

	// --------------------------------------------------------- commit
	// A hit keeps its dirty bit; any store leaves the line dirty; a load that
	// evicts a dirty line leaves it clean.
	always_comb begin
		wr_flags.valid = 1'b1;
		wr_flags.dirty = (store_q == slc_pkg::REQ_STORE) || (scan_res.hit && scan_res.old_dirty);
		dirty_inc      = (store_q == slc_pkg::REQ_STORE) && !scan_res.old_dirty;
		dirty_dec      = scan_res.evict && scan_res.old_dirty
			&& (store_q == slc_pkg::REQ_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_q    <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evictions_q <= '0;
			dirty_out_q <= '0;
			dirty_now_q <= '0;
		end else begin
			access_q <= sat_inc(access_q, accept);
			if (commit) begin
				hits_q      <= sat_inc(hits_q, scan_res.hit);
				misses_q    <= sat_inc(misses_q, !scan_res.hit);
				evictions_q <= sat_inc(evictions_q, scan_res.evict);
				dirty_out_q <= sat_inc(dirty_out_q, scan_res.evict && scan_res.old_dirty);
				dirty_now_q <= dirty_now_q + slc_pkg::DIRTY_W'(dirty_inc)
					- slc_pkg::DIRTY_W'(dirty_dec);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			was_hit_q       <= scan_res.hit;
			was_eviction_q  <= scan_res.evict;
			evicted_dirty_q <= scan_res.evict && scan_res.old_dirty;
		end
	end

	// Totals change only at a commit, which also reloads the output register,
	// so they always belong to the beat on display.
	assign rsp.valid                 = out_valid_q;
	assign rsp.was_hit               = was_hit_q;
	assign rsp.was_eviction          = was_eviction_q;
	assign rsp.evicted_dirty         = evicted_dirty_q;
	assign rsp.hit_total             = out_sat(hits_q);
	assign rsp.miss_total            = out_sat(misses_q);
	assign rsp.eviction_total        = out_sat(evictions_q);
	assign rsp.dirty_resident_blocks = dirty_now_q;
	assign rsp.dirty_evicted_total   = out_sat(dirty_out_q);

endmodule

`default_nettype wire

// ===== sv/slc_checker.sv =====
// ----------------------------------------------------------------------------
// slc_checker - port-level checks for the LRU cache tracker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic                        was_hit,
	input wire logic                        was_eviction,
	input wire logic                        evicted_dirty,
	input wire logic [slc_pkg::TOTAL_W-1:0] hit_total
);

	// The block works on one access at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an access is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped before it was taken");

	// An eviction happens only on a miss, and a dirty eviction is an eviction.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(was_eviction && was_hit) && (!evicted_dirty || was_eviction))
		else $error("inconsistent outcome flags");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hit_total >= $past(hit_total))
		else $error("hit total went backward");

endmodule

bind set_assoc_lru_cache_tracker slc_checker u_slc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.was_hit       (rsp.was_hit),
	.was_eviction  (rsp.was_eviction),
	.evicted_dirty (rsp.evicted_dirty),
	.hit_total     (rsp.hit_total)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the set-associative LRU cache tracker
// Drives load and store beats through a run of cache geometries, tracks the
// cache in a shadow copy and checks every result beat field by field. The
// sender and the receiver idle at random, at rates that change per phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_S      = slc_pkg::DEF_MAX_SET_BITS;
	localparam int NWAYS      = slc_pkg::DEF_WAYS;
	localparam int LINES      = (1 << MAX_S) * NWAYS;
	localparam int LATENCY    = 4 + 2 * NWAYS;
	localparam int CYCLE_CAP  = 600000;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 117;
	localparam logic [slc_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic                        was_hit;
		logic                        was_eviction;
		logic                        evicted_dirty;
		logic [slc_pkg::TOTAL_W-1:0] hit_total;
		logic [slc_pkg::TOTAL_W-1:0] miss_total;
		logic [slc_pkg::TOTAL_W-1:0] eviction_total;
		logic [slc_pkg::DIRTY_W-1:0] dirty_resident_blocks;
		logic [slc_pkg::TOTAL_W-1:0] dirty_evicted_total;
	} outcome_t;

	// Shadow of the cache state and the outcomes still owed by the block.
	class cache_shadow;
		logic [3:0]                  set_bits;
		logic [3:0]                  ways_used;
		logic [5:0]                  block_bits;
		bit                          line_valid [LINES];
		bit                          line_dirty [LINES];
		logic [slc_pkg::TAG_W-1:0]   line_tag [LINES];
		logic [slc_pkg::TOTAL_W-1:0] line_stamp [LINES];
		logic [slc_pkg::TOTAL_W-1:0] accesses, hits, misses, evictions, dirty_out;
		int unsigned                 dirty_held;
		outcome_t                    owed_outcomes [$];
		int                          errors;

		function new();
			set_bits   = slc_pkg::RST_SET_BITS;
			ways_used  = slc_pkg::RST_WAYS_USED;
			block_bits = slc_pkg::RST_BLOCK_BITS;
			foreach (line_valid[i]) begin
				line_valid[i] = 1'b0;
				line_dirty[i] = 1'b0;
				line_tag[i]   = '0;
				line_stamp[i] = '0;
			end
			accesses   = '0;
			hits       = '0;
			misses     = '0;
			evictions  = '0;
			dirty_out  = '0;
			dirty_held = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [slc_pkg::CFG_IDX_W-1:0] idx,
				logic [slc_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				slc_pkg::REG_SET_BITS:   set_bits = val[3:0];
				slc_pkg::REG_WAYS_USED:  ways_used = val[3:0];
				slc_pkg::REG_BLOCK_BITS: block_bits = val;
				default: ;
			endcase
		endfunction

		function int unsigned set_span();
			return (set_bits > MAX_S) ? MAX_S : set_bits;
		endfunction

		function int unsigned way_span();
			if (ways_used == 0)
				return 1;
			return (ways_used > NWAYS) ? NWAYS : ways_used;
		endfunction

		function logic [slc_pkg::TOTAL_W-1:0] bump(logic [slc_pkg::TOTAL_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function int pending();
			return owed_outcomes.size();
		endfunction

		function void note_access(logic kind, logic [slc_pkg::ADDR_W-1:0] addr);
			int unsigned s, b, nways, base, victim, k, i;
			logic [slc_pkg::TAG_W-1:0] tag_v;
			outcome_t r;
			s = set_span();
			b = block_bits;
			nways = way_span();
			base = int'((addr >> b) & ((64'd1 << s) - 64'd1)) * NWAYS;
			tag_v = (s + b < 64) ? (addr >> (s + b)) : '0;
			r = '0;
			accesses = bump(accesses);

			for (i = 0; i < nways; i++) begin
				k = base + i;
				if (!r.was_hit && line_valid[k] && line_tag[k] == tag_v) begin
					r.was_hit = 1'b1;
					hits = bump(hits);
					line_stamp[k] = accesses;
					if (kind == slc_pkg::REQ_STORE && !line_dirty[k]) begin
						line_dirty[k] = 1'b1;
						dirty_held++;
					end
				end
			end

			if (!r.was_hit) begin
				misses = bump(misses);
				victim = nways;
				for (i = 0; i < nways; i++)
					if (victim == nways && !line_valid[base + i])
						victim = i;
				if (victim < nways) begin
					k = base + victim;
					line_valid[k] = 1'b1;
					line_tag[k]   = tag_v;
					line_stamp[k] = accesses;
					if (kind == slc_pkg::REQ_STORE) begin
						if (!line_dirty[k])
							dirty_held++;
						line_dirty[k] = 1'b1;
					end
				end else begin
					// Oldest stamp goes; the strict compare keeps the lowest way on ties.
					victim = 0;
					for (i = 1; i < nways; i++)
						if (line_stamp[base + i] < line_stamp[base + victim])
							victim = i;
					k = base + victim;
					r.was_eviction = 1'b1;
					evictions = bump(evictions);
					line_tag[k]   = tag_v;
					line_stamp[k] = accesses;
					if (line_dirty[k]) begin
						r.evicted_dirty = 1'b1;
						dirty_out = bump(dirty_out);
						if (kind == slc_pkg::REQ_LOAD) begin
							line_dirty[k] = 1'b0;
							if (dirty_held > 0)
								dirty_held--;
						end
					end else if (kind == slc_pkg::REQ_STORE) begin
						line_dirty[k] = 1'b1;
						dirty_held++;
					end
				end
			end

			r.hit_total             = hits;
			r.miss_total            = misses;
			r.eviction_total        = evictions;
			r.dirty_resident_blocks = slc_pkg::DIRTY_W'(dirty_held);
			r.dirty_evicted_total   = dirty_out;
			owed_outcomes.push_back(r);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (owed_outcomes.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, got);
				return;
			end
			want = owed_outcomes.pop_front();
			compare_field("was_hit", 64'(want.was_hit), 64'(got.was_hit));
			compare_field("was_eviction", 64'(want.was_eviction), 64'(got.was_eviction));
			compare_field("evicted_dirty", 64'(want.evicted_dirty), 64'(got.evicted_dirty));
			compare_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
			compare_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
			compare_field("eviction_total", 64'(want.eviction_total),
				64'(got.eviction_total));
			compare_field("dirty_resident_blocks", 64'(want.dirty_resident_blocks),
				64'(got.dirty_resident_blocks));
			compare_field("dirty_evicted_total", 64'(want.dirty_evicted_total),
				64'(got.dirty_evicted_total));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [slc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [slc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	slc_req_if req_bus ();
	slc_rsp_if rsp_bus ();

	cache_shadow shadow = new();
	outcome_t seen;
	int idle_pct;
	int stall_pct;
	int cycles;

	// Setting per phase: set_bits, ways_used, block_bits as written.
	int set_plan [PHASES]  = '{2, 0, 8, 15, 3, 1, 8, 5};
	int ways_plan [PHASES] = '{4, 8, 8, 0, 15, 2, 3, 7};
	int blk_plan [PHASES]  = '{3, 0, 55, 63, 6, 60, 56, 1};

	// Direct-mapped opening run at the reset geometry: {kind, address}.
	logic [64:0] warmup [15] = '{
		{slc_pkg::REQ_LOAD,  64'h0000_0000_0000_0000},
		{slc_pkg::REQ_LOAD,  64'h0000_0000_0000_0008},
		{slc_pkg::REQ_STORE, 64'h0000_0000_0000_0000},
		{slc_pkg::REQ_LOAD,  64'h0000_0000_0000_0100},
		{slc_pkg::REQ_STORE, 64'h0000_0000_0000_0200},
		{slc_pkg::REQ_STORE, 64'h0000_0000_0000_0300},
		{slc_pkg::REQ_STORE, 64'h0000_0000_0000_0300},
		{slc_pkg::REQ_LOAD,  64'hFFFF_FFFF_FFFF_FFFF},
		{slc_pkg::REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF},
		{slc_pkg::REQ_LOAD,  64'h7FFF_FFFF_FFFF_FFFF},
		{slc_pkg::REQ_STORE, 64'h8000_0000_0000_0000},
		{slc_pkg::REQ_LOAD,  64'h0000_0000_0000_0010},
		{slc_pkg::REQ_STORE, 64'h5555_5555_5555_5555},
		{slc_pkg::REQ_STORE, 64'hAAAA_AAAA_AAAA_AAAA},
		{slc_pkg::REQ_LOAD,  64'h5555_5555_5555_5555}
	};

	set_assoc_lru_cache_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Results are checked before the same edge's access is noted, so a stray
	// result beat can never consume an expectation it did not cause.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				seen.was_hit               = rsp_bus.was_hit;
				seen.was_eviction          = rsp_bus.was_eviction;
				seen.evicted_dirty         = rsp_bus.evicted_dirty;
				seen.hit_total             = rsp_bus.hit_total;
				seen.miss_total            = rsp_bus.miss_total;
				seen.eviction_total        = rsp_bus.eviction_total;
				seen.dirty_resident_blocks = rsp_bus.dirty_resident_blocks;
				seen.dirty_evicted_total   = rsp_bus.dirty_evicted_total;
				shadow.check_outcome(seen);
			end
			if (req_bus.valid && req_bus.ready)
				shadow.note_access(req_bus.req_type, req_bus.address);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_access(input logic kind, input logic [slc_pkg::ADDR_W-1:0] addr);
		if ($urandom_range(99) < idle_pct) begin
			req_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_bus.valid    <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.address  <= addr;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	// Hold the request side quiet until every owed result beat has arrived.
	// The first edge lets the monitor note a beat accepted at the edge just past.
	task automatic settle();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three registers, then an unmapped index that must be ignored.
	task automatic configure(input logic [3:0] sets, input logic [3:0] ways,
			input logic [5:0] blk);
		logic [slc_pkg::CFG_DATA_W-1:0] junk;
		junk = slc_pkg::CFG_DATA_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= slc_pkg::REG_SET_BITS;
		cfg_wdata <= {2'($urandom_range(3)), sets};
		shadow.set_reg(slc_pkg::REG_SET_BITS, {2'b00, sets});
		@(posedge clk);
		cfg_index <= slc_pkg::REG_WAYS_USED;
		cfg_wdata <= {2'($urandom_range(3)), ways};
		shadow.set_reg(slc_pkg::REG_WAYS_USED, {2'b00, ways});
		@(posedge clk);
		cfg_index <= slc_pkg::REG_BLOCK_BITS;
		cfg_wdata <= blk;
		shadow.set_reg(slc_pkg::REG_BLOCK_BITS, blk);
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_wdata <= junk;
		shadow.set_reg(REG_NONE, junk);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly reuse of a small working set of tags in two sets, so that hits,
	// fills and LRU evictions all occur; one beat in ten is a raw address.
	task automatic run_phase(input int n_items);
		logic [slc_pkg::TAG_W-1:0] hot_tag [10];
		int unsigned hot_set [2];
		logic [slc_pkg::ADDR_W-1:0] addr, low;
		int unsigned s, b, ntags;
		int i;
		s = shadow.set_span();
		b = shadow.block_bits;
		ntags = shadow.way_span() + 1 + $urandom_range(1);
		foreach (hot_tag[j])
			hot_tag[j] = {$urandom, $urandom};
		foreach (hot_set[j])
			hot_set[j] = $urandom_range((1 << s) - 1);
		for (i = 0; i < n_items; i++) begin
			low = {$urandom, $urandom};
			if ($urandom_range(9) == 0) begin
				addr = low;
			end else begin
				addr = low & ((64'd1 << b) - 64'd1);
				addr |= 64'(hot_set[$urandom_range(1)]) << b;
				if (s + b < 64)
					addr |= hot_tag[$urandom_range(ntags - 1)] << (s + b);
			end
			send_access(1'($urandom_range(1)), addr);
			if ($urandom_range(149) == 0)
				settle();
		end
	endtask

	initial begin
		int p;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = slc_pkg::REG_SET_BITS;
		cfg_wdata         = '0;
		req_bus.valid     = 1'b0;
		req_bus.req_type  = slc_pkg::REQ_LOAD;
		req_bus.address   = '0;
		rsp_bus.ready     = 1'b0;
		idle_pct          = 0;
		stall_pct         = 0;
		cycles            = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (warmup[i])
			send_access(warmup[i][64], warmup[i][63:0]);
		settle();

		for (p = 0; p < PHASES; p++) begin
			configure(set_plan[p], ways_plan[p], blk_plan[p]);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 88; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 88; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			run_phase(PHASE_LEN);
			settle();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (shadow.pending() != 0) begin
			shadow.errors++;
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, shadow.pending());
		end
		if (shadow.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/slc_pkg.sv
sv/slc_req_if.sv
sv/slc_rsp_if.sv
sv/slc_line_store.sv
sv/slc_way_scan.sv
sv/set_assoc_lru_cache_tracker.sv
sv/slc_checker.sv
dv/tb.sv
